/* rtl/grid_segment_collision_check_top_defines.svh */
// Assertion macros for the segment collision check RTL.
`ifndef GRID_SEGMENT_COLLISION_CHECK_TOP_DEFINES_SVH
`define GRID_SEGMENT_COLLISION_CHECK_TOP_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define GSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define GSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gsc_pkg.sv */
// Shared constants, codes and types for the segment collision check block.
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

  // Grid geometry.
  localparam int X_BITS = 9;
  localparam int Y_BITS = 9;
  localparam int C_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int ADDR_W = X_BITS + Y_BITS;
  localparam int CELLS  = 1 << ADDR_W;
  // Remainder width: holds the sum of a remainder and a signed delta.
  localparam int R_W    = C_BITS + 2;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  typedef logic [C_BITS-1:0]        coord_t;
  typedef logic signed [C_BITS:0]   delta_t;
  typedef logic signed [R_W-1:0]    rem_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  // Segment check handed from the input side to the walker.
  typedef struct packed {
    logic              valid;
    logic [X_BITS-1:0] ax;
    logic [Y_BITS-1:0] ay;
    logic [X_BITS-1:0] bx;
    logic [Y_BITS-1:0] by;
  } check_req_t;

  // Grid read request from the walker.
  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

endpackage

`default_nettype wire

/* rtl/gsc_grid_ram.sv */
// One-bit occupancy grid memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gsc_grid_ram (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire gsc_pkg::addr_t  wr_addr,
  input  wire logic            wr_data,
  input  wire gsc_pkg::rd_req_t rd_req,
  output logic                 rd_data
);

  logic mem [0:gsc_pkg::CELLS-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/gsc_walker.sv */
// Segment walker: sets up the major axis and steps one grid read per cell.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_segment_collision_check_top_defines.svh"

module gsc_walker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gsc_pkg::check_req_t req,
  output logic                     idle,
  output gsc_pkg::rd_req_t         rd_req,
  input  wire logic                rd_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     clear
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]      state;
  gsc_pkg::coord_t step_index;
  gsc_pkg::coord_t quot;
  gsc_pkg::rem_t   rem;
  gsc_pkg::coord_t major;
  gsc_pkg::coord_t span;
  gsc_pkg::delta_t delta;
  logic            x_major;
  logic            pending;
  logic            result;

  gsc_pkg::coord_t ax_c, ay_c, bx_c, by_c, dx, dy;
  gsc_pkg::coord_t sm_c, em_c, sn_c, en_c, span_c;
  gsc_pkg::delta_t delta_c;
  logic            x_major_c;

  gsc_pkg::rem_t   rem_sum, span_s, rem_next;
  gsc_pkg::coord_t quot_next, major_next, step_next;
  logic            stop, go;
  logic            load_out;
  gsc_pkg::coord_t addr_x, addr_y;

  // Setup: pick the major axis and the start endpoint.
  always_comb begin
    ax_c      = gsc_pkg::C_BITS'(req.ax);
    ay_c      = gsc_pkg::C_BITS'(req.ay);
    bx_c      = gsc_pkg::C_BITS'(req.bx);
    by_c      = gsc_pkg::C_BITS'(req.by);
    dx        = (ax_c > bx_c) ? (ax_c - bx_c) : (bx_c - ax_c);
    dy        = (ay_c > by_c) ? (ay_c - by_c) : (by_c - ay_c);
    x_major_c = (dx >= dy);
    if (x_major_c) begin
      sm_c = (ax_c < bx_c) ? ax_c : bx_c;
      em_c = (ax_c < bx_c) ? bx_c : ax_c;
      sn_c = (ax_c < bx_c) ? ay_c : by_c;
      en_c = (ax_c < bx_c) ? by_c : ay_c;
    end else begin
      sm_c = (ay_c < by_c) ? ay_c : by_c;
      em_c = (ay_c < by_c) ? by_c : ay_c;
      sn_c = (ay_c < by_c) ? ax_c : bx_c;
      en_c = (ay_c < by_c) ? bx_c : ax_c;
    end
    span_c  = em_c - sm_c;
    delta_c = gsc_pkg::delta_t'({1'b0, en_c}) - gsc_pkg::delta_t'({1'b0, sn_c});
  end

  // One step: add the delta to the remainder and correct it once.
  always_comb begin
    span_s  = gsc_pkg::rem_t'({2'b00, span});
    rem_sum = rem + gsc_pkg::rem_t'({delta[gsc_pkg::C_BITS], delta});
    if (rem_sum >= span_s) begin
      rem_next  = rem_sum - span_s;
      quot_next = quot + 1'b1;
    end else if (rem_sum < 0) begin
      rem_next  = rem_sum + span_s;
      quot_next = quot - 1'b1;
    end else begin
      rem_next  = rem_sum;
      quot_next = quot;
    end
    major_next = major + 1'b1;
    step_next  = step_index + 1'b1;
  end

  // A read issued last cycle that returns an obstacle ends the walk.
  assign stop = pending && rd_data;
  assign go   = (state == S_WALK) && (step_index != span) && !stop;

  // A finished result moves to the output register once that register is free.
  assign load_out = (state == S_HOLD) && (!out_valid || out_ready);

  // Grid address of the next cell on the walk.
  always_comb begin
    addr_x = x_major ? major_next : quot_next;
    addr_y = x_major ? quot_next : major_next;
  end

  assign rd_req.en   = go;
  assign rd_req.addr = {addr_x[gsc_pkg::X_BITS-1:0], addr_y[gsc_pkg::Y_BITS-1:0]};
  assign idle        = (state == S_IDLE);

  // Sequencer, walk registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_index <= '0;
      quot       <= '0;
      rem        <= '0;
      pending    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        clear     <= result;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            step_index <= '0;
            quot       <= sn_c;
            rem        <= '0;
            major      <= sm_c;
            span       <= span_c;
            delta      <= delta_c;
            x_major    <= x_major_c;
            pending    <= 1'b0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          pending <= go;
          if (go) begin
            step_index <= step_next;
            quot       <= quot_next;
            rem        <= rem_next;
            major      <= major_next;
          end
          if (stop) begin
            result <= 1'b0;
            state  <= S_HOLD;
          end else if (!pending && (step_index == span)) begin
            result <= 1'b1;
            state  <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GSC_ASSERT_SAME(a_rem_range, state == S_WALK, (rem >= 0) && ((rem < span_s) || (span == '0)), "walker remainder out of range")
  `GSC_ASSERT_SAME(a_step_bound, state == S_WALK, step_index <= span, "walker stepped past the span")
  `GSC_ASSERT_NEXT(a_start_load, (state == S_IDLE) && req.valid, (state == S_WALK) && (step_index == '0) && !pending, "walk did not start cleanly")
  `GSC_ASSERT_NEXT(a_block_result, stop, (state == S_HOLD) && !result, "obstacle did not end the walk as blocked")

endmodule

`default_nettype wire

/* rtl/grid_segment_collision_check_top.sv */
// Top level of the segment collision check over a one-bit occupancy grid.
// Usage:
// - Input channel (in_valid/in_ready) carries command, ax, ay, bx, by and
//   cell_value. A write command stores cell_value at (ax, ay) and gives no
//   result; the block is ready again next cycle.
// - A check command walks the segment from the endpoint with the smaller
//   major coordinate and gives one result on the output channel
//   (out_valid/out_ready): clear is 1 if no visited cell is an obstacle.
// - A check makes one grid read per cell of its major span, through the
//   single read port. An obstacle ends the walk early.
// - One item is handled at a time; in_ready is high only while no check is
//   being walked. A finished result waits in the output register, and the
//   block accepts the next item while that result is not yet taken.
// - If the receiver stalls, a second finished result waits inside the
//   walker until the output register is free.
// - Reset (rst, synchronous, active high) clears the control state. The
//   grid is not cleared: every cell must be written before a check reads it.
`timescale 1ns / 1ps
`default_nettype none

module grid_segment_collision_check_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       command,
  input  wire logic [gsc_pkg::X_BITS-1:0] ax,
  input  wire logic [gsc_pkg::Y_BITS-1:0] ay,
  input  wire logic [gsc_pkg::X_BITS-1:0] bx,
  input  wire logic [gsc_pkg::Y_BITS-1:0] by,
  input  wire logic                       cell_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            clear
);

  logic                accept;
  logic                idle;
  logic                wr_en;
  gsc_pkg::addr_t      wr_addr;
  gsc_pkg::check_req_t req;
  gsc_pkg::rd_req_t    rd_req;
  logic                rd_data;

  // Input transfer and command decode.
  assign in_ready = idle;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (command == gsc_pkg::CMD_WRITE);
  assign wr_addr  = {ax, ay};

  always_comb begin
    req.valid = accept && (command == gsc_pkg::CMD_CHECK);
    req.ax    = ax;
    req.ay    = ay;
    req.bx    = bx;
    req.by    = by;
  end

  // Occupancy grid.
  gsc_grid_ram u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cell_value),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  // Segment walker and result register.
  gsc_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .idle      (idle),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .clear     (clear)
  );

endmodule

`default_nettype wire
